### rtl/mct_pkg.sv
// shared types, codes and helpers of the multi-channel timeout table
`default_nettype none
package mct_pkg;
	localparam int OP_W     = 4;
	localparam int ID_W     = 4;
	localparam int STAMP_W  = 48;
	localparam int PERIOD_W = 32;
	localparam int STAT_W   = 2;

	localparam int DEF_CHANNELS = 16;
	localparam int MAX_FIRES    = 16;
	localparam int FW           = $clog2(MAX_FIRES + 1);

	localparam logic [OP_W-1:0] OP_REGISTER  = 4'd0;
	localparam logic [OP_W-1:0] OP_CHANGE    = 4'd1;
	localparam logic [OP_W-1:0] OP_RESET     = 4'd2;
	localparam logic [OP_W-1:0] OP_PAUSE     = 4'd3;
	localparam logic [OP_W-1:0] OP_START     = 4'd4;
	localparam logic [OP_W-1:0] OP_PAUSE_ALL = 4'd5;
	localparam logic [OP_W-1:0] OP_START_ALL = 4'd6;
	localparam logic [OP_W-1:0] OP_QUERY     = 4'd7;
	localparam logic [OP_W-1:0] OP_TICK      = 4'd8;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

	localparam logic KIND_ACK  = 1'b0;
	localparam logic KIND_FIRE = 1'b1;

	// one channel record as kept in the table memory
	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [STAMP_W-1:0]  rst;
		logic [STAMP_W-1:0]  fire;
		logic                run;
		logic                shot;
	} mct_rec_t;

	typedef struct packed {
		logic latch;
		logic rd;
		logic ev;
		logic ack;
		logic fin;
	} mct_cmd_t;

	typedef struct packed {
		logic is_chan;
		logic is_scan;
		logic is_tick;
		logic known;
		logic used_zero;
		logic last;
		logic out_free;
	} mct_sts_t;

	function automatic logic elapsed(input logic [STAMP_W-1:0] now,
		input logic [STAMP_W-1:0] then_t, input logic [PERIOD_W-1:0] len);
		logic [STAMP_W-1:0] diff;
		diff = now - then_t;
		return (now >= then_t) && (diff >= STAMP_W'(len));
	endfunction

	function automatic logic op_is_chan(input logic [OP_W-1:0] op);
		return op == OP_CHANGE || op == OP_RESET || op == OP_PAUSE ||
			op == OP_START || op == OP_QUERY;
	endfunction

	function automatic logic op_is_scan(input logic [OP_W-1:0] op);
		return op == OP_PAUSE_ALL || op == OP_START_ALL || op == OP_TICK;
	endfunction
endpackage
`default_nettype wire

### rtl/mct_in_if.sv
// input item channel of the timeout table
`default_nettype none
interface mct_in_if
	import mct_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [ID_W-1:0]     chan;
	logic [STAMP_W-1:0]  stamp_in;
	logic [PERIOD_W-1:0] period;
	logic                single_shot;
	logic                run_now;

	modport source(output valid, op, chan, stamp_in, period, single_shot, run_now,
		input ready);
	modport sink(input valid, op, chan, stamp_in, period, single_shot, run_now,
		output ready);
endinterface
`default_nettype wire

### rtl/mct_out_if.sv
// result item channel of the timeout table
`default_nettype none
interface mct_out_if
	import mct_pkg::*;
	;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [ID_W-1:0]    entry_id;
	logic [STAMP_W-1:0] stamp_out;
	logic               is_running;
	logic [STAT_W-1:0]  status;
	logic               final_res;

	modport source(output valid, kind, entry_id, stamp_out, is_running, status, final_res,
		input ready);
	modport sink(input valid, kind, entry_id, stamp_out, is_running, status, final_res,
		output ready);
endinterface
`default_nettype wire

### rtl/mct_dpath.sv
// datapath: channel memory, timeout compare, pending fire and result register
`default_nettype none
module mct_dpath
	import mct_pkg::*;
#(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire mct_cmd_t       cmd,
	output mct_sts_t            sts,
	input  wire [OP_W-1:0]      op,
	input  wire [ID_W-1:0]      chan,
	input  wire [STAMP_W-1:0]   stamp_in,
	input  wire [PERIOD_W-1:0]  period,
	input  wire                 single_shot,
	input  wire                 run_now,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic                kind,
	output logic [ID_W-1:0]     entry_id,
	output logic [STAMP_W-1:0]  stamp_out,
	output logic                is_running,
	output logic [STAT_W-1:0]   status,
	output logic                final_res
);
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int UW = $clog2(CHANNELS + 1);
	localparam int KW = (UW > ID_W) ? UW : ID_W;

	mct_rec_t mem_q [CHANNELS];
	mct_rec_t rd_q;
	mct_rec_t wr_rec;

	logic [OP_W-1:0]     op_q;
	logic [ID_W-1:0]     chan_q;
	logic [STAMP_W-1:0]  stamp_q;
	logic [PERIOD_W-1:0] per_q;
	logic                shot_q;
	logic                run_q;
	logic [UW-1:0]       used_q;
	logic [IW-1:0]       idx_q;
	logic [FW-1:0]       nfire_q;
	logic                pend_v_q;
	logic [ID_W-1:0]     pend_id_q;
	logic [STAMP_W-1:0]  pend_stamp_q;

	logic          full;
	logic          fire;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [UW:0]   idx_nx;
	logic          push;
	logic          emit;

	assign full   = used_q == UW'(CHANNELS);
	assign fire   = rd_q.run && elapsed(stamp_q, rd_q.rst, rd_q.period) &&
		elapsed(stamp_q, rd_q.fire, rd_q.period);
	assign idx_nx = (UW+1)'(idx_q) + (UW+1)'(1);

	assign sts.is_chan   = op_is_chan(op_q);
	assign sts.is_scan   = op_is_scan(op_q);
	assign sts.is_tick   = op_q == OP_TICK;
	assign sts.known     = KW'(chan_q) < KW'(used_q);
	assign sts.used_zero = used_q == '0;
	assign sts.last      = (idx_nx >= (UW+1)'(used_q)) ||
		(op_q == OP_TICK && fire && nfire_q == FW'(MAX_FIRES - 1));
	assign sts.out_free  = !out_valid || out_ready;

	// record after the operation on the entry just read
	always_comb begin
		wr_rec = rd_q;
		case (op_q)
			OP_CHANGE: begin
				wr_rec.shot   = shot_q;
				wr_rec.run    = run_q;
				wr_rec.period = per_q;
				wr_rec.rst    = stamp_q;
			end
			OP_RESET: wr_rec.rst = stamp_q;
			OP_PAUSE, OP_PAUSE_ALL: wr_rec.run = 1'b0;
			OP_START, OP_START_ALL: begin
				wr_rec.run = 1'b1;
				wr_rec.rst = stamp_q;
			end
			OP_TICK: begin
				if (fire) begin
					wr_rec.fire = stamp_q;
					if (rd_q.shot) wr_rec.run = 1'b0;
				end
			end
			OP_REGISTER: begin
				wr_rec.period = per_q;
				wr_rec.rst    = stamp_q;
				wr_rec.fire   = stamp_q;
				wr_rec.run    = run_q;
				wr_rec.shot   = shot_q;
			end
			default: wr_rec = rd_q;
		endcase
	end

	assign wr_en = (cmd.ev && op_q != OP_QUERY) ||
		(cmd.ack && op_q == OP_REGISTER && !full);
	assign wr_addr = cmd.ack ? IW'(used_q) : idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_rec;
		if (cmd.rd) rd_q <= mem_q[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op;
			chan_q  <= chan;
			stamp_q <= stamp_in;
			per_q   <= period;
			shot_q  <= single_shot;
			run_q   <= run_now;
		end
		if (cmd.ev && op_q == OP_TICK && fire) begin
			pend_id_q    <= ID_W'(idx_q);
			pend_stamp_q <= rd_q.rst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			idx_q    <= '0;
			nfire_q  <= '0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				idx_q    <= op_is_chan(op) ? IW'(chan) : '0;
				nfire_q  <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.ev && sts.is_scan) idx_q <= IW'(idx_nx);
			if (cmd.ev && op_q == OP_TICK && fire) begin
				nfire_q  <= nfire_q + FW'(1);
				pend_v_q <= 1'b1;
			end
			if (cmd.fin) pend_v_q <= 1'b0;
			if (cmd.ack && op_q == OP_REGISTER && !full) used_q <= used_q + UW'(1);
		end
	end

	assign push = cmd.ev && op_q == OP_TICK && fire && pend_v_q;
	assign emit = cmd.ack || cmd.fin || push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind       <= KIND_ACK;
			entry_id   <= '0;
			stamp_out  <= '0;
			is_running <= 1'b0;
			status     <= ST_OK;
			final_res  <= 1'b1;
			if (push || (cmd.fin && pend_v_q)) begin
				kind      <= KIND_FIRE;
				entry_id  <= pend_id_q;
				stamp_out <= pend_stamp_q;
				final_res <= cmd.fin;
			end else if (cmd.ack) begin
				if (op_q == OP_REGISTER) begin
					if (full) status <= ST_FULL;
					else entry_id <= ID_W'(used_q);
				end else if (sts.is_chan) begin
					entry_id <= chan_q;
					if (!sts.known) begin
						status <= ST_UNKNOWN;
					end else if (op_q == OP_QUERY) begin
						stamp_out  <= rd_q.rst;
						is_running <= rd_q.run;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

### rtl/mct_ctrl.sv
// controller: sequences reads, updates and results for one item at a time
`default_nettype none
module mct_ctrl
	import mct_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_ready,
	input  wire mct_sts_t sts,
	output mct_cmd_t      cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_EVAL = 3'd3;
	localparam logic [2:0] S_ACK  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nx  = S_DISP;
				end
			end
			S_DISP: begin
				if ((sts.is_chan && sts.known) || (sts.is_scan && !sts.used_zero))
					state_nx = S_READ;
				else if (sts.is_tick)
					state_nx = S_FIN;
				else
					state_nx = S_ACK;
			end
			S_READ: begin
				cmd.rd   = 1'b1;
				state_nx = S_EVAL;
			end
			S_EVAL: begin
				if (sts.out_free) begin
					cmd.ev = 1'b1;
					if (!sts.is_scan) state_nx = S_ACK;
					else if (!sts.last) state_nx = S_READ;
					else if (sts.is_tick) state_nx = S_FIN;
					else state_nx = S_ACK;
				end
			end
			S_ACK: begin
				if (sts.out_free) begin
					cmd.ack  = 1'b1;
					state_nx = S_IDLE;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin  = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end
endmodule
`default_nettype wire

### rtl/multi_channel_timeout_table.sv
// multi-channel timeout table: watchdog channels with register, control and tick scan
//
// in_ch carries one operation per item (register, change, reset, pause, start,
// pause_all, start_all, query, tick); out_ch carries the results. Every
// operation other than a tick gives one acknowledge item; a tick gives one
// fire item per firing channel (at most 16), or one acknowledge when nothing
// fires. The last result of an operation has final_res set.
// One item is taken at a time. A register, an unknown op or an unregistered
// id goes from dispatch straight to its result; a single-channel op on a
// registered id first reads and updates the entry (read, update, result).
// pause_all, start_all and tick walk the registered channels through the
// single-port channel memory, each channel in a read step, then a compare
// and write-back step; a tick ends its walk after its sixteenth fire.
// A fire item is held back one step so the final flag can be set on the
// last one. The result register decouples the sides: when the receiver
// stalls, the walk waits at its next step and resumes when the result is taken.
// Reset empties the table (count zero) and drops any held result; entry
// contents are only read after being registered, so no clearing pass runs.
`default_nettype none
module multi_channel_timeout_table
	import mct_pkg::*;
#(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input wire        clk,
	input wire        arst_n,
	mct_in_if.sink    in_ch,
	mct_out_if.source out_ch
);
	mct_cmd_t cmd;
	mct_sts_t sts;

	// sequencing of one item
	mct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table memory, compare and result register
	mct_dpath #(
		.CHANNELS (CHANNELS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (in_ch.op),
		.chan        (in_ch.chan),
		.stamp_in    (in_ch.stamp_in),
		.period      (in_ch.period),
		.single_shot (in_ch.single_shot),
		.run_now     (in_ch.run_now),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.kind        (out_ch.kind),
		.entry_id    (out_ch.entry_id),
		.stamp_out   (out_ch.stamp_out),
		.is_running  (out_ch.is_running),
		.status      (out_ch.status),
		.final_res   (out_ch.final_res)
	);

	// an accepted item keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("item accepted while previous one in progress");

	// fire items always report ok and no running flag
	a_fire_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.kind == KIND_FIRE |->
		out_ch.status == ST_OK && !out_ch.is_running)
		else $error("fire item with bad status or running flag");

	// the tick-end step is only taken for ticks
	a_fin_tick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> sts.is_tick)
		else $error("tick end issued for a non-tick item");
endmodule
`default_nettype wire
